/* src/ssm_pkg.sv */
// Shared types and constants for the symmetric sparse matrix-vector multiplier.
`timescale 1ns / 1ps
package ssm_pkg;

	localparam int MAX_SIZE    = 1024;
	localparam int POS_W       = $clog2(MAX_SIZE);
	localparam int INDEX_W     = 11;
	localparam int VALUE_W     = 32;
	localparam int ACC_W       = 64;
	localparam int SIZE_W      = 11;
	localparam int IN_DATA_W   = 56;
	localparam int VAL_LSB     = 2 * INDEX_W;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_ENTRY = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_SAT  = 2'd2,
		STAT_RSVD = 2'd3
	} status_t;

	typedef enum logic {
		REG_MATRIX_SIZE = 1'b0,
		REG_INDEX_BASE  = 1'b1
	} cfg_reg_t;

endpackage

/* src/ssm_mac.sv */
// Shared multiplier with registered product and saturating 64-bit accumulate.
`timescale 1ns / 1ps
module ssm_mac (
	input  logic                                clk,
	input  logic                                mul_en,
	input  logic signed [ssm_pkg::VALUE_W-1:0]  mul_a,
	input  logic signed [ssm_pkg::VALUE_W-1:0]  mul_b,
	input  logic signed [ssm_pkg::ACC_W-1:0]    acc_in,
	output logic signed [ssm_pkg::ACC_W-1:0]    sum,
	output logic                                sat
);

	logic signed [ssm_pkg::ACC_W-1:0] prod_q;
	logic signed [ssm_pkg::ACC_W-1:0] raw_sum;
	logic                             ovf;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= ssm_pkg::ACC_W'(mul_a * mul_b);
		end
	end

	always_comb begin
		raw_sum = acc_in + prod_q;
		ovf     = (acc_in[ssm_pkg::ACC_W-1] == prod_q[ssm_pkg::ACC_W-1]) &&
		          (raw_sum[ssm_pkg::ACC_W-1] != acc_in[ssm_pkg::ACC_W-1]);
		sat     = ovf;
		if (ovf) begin
			sum = acc_in[ssm_pkg::ACC_W-1] ? {1'b1, {(ssm_pkg::ACC_W-1){1'b0}}}
			                               : {1'b0, {(ssm_pkg::ACC_W-1){1'b1}}};
		end else begin
			sum = raw_sum;
		end
	end

endmodule

/* src/symmetric_sparse_matvec_top.sv */
// Top level of the symmetric sparse matrix-vector multiplier (lower triangle stored).
`timescale 1ns / 1ps
// Usage:
//   s_* channel takes one request per transaction: tuser is the request kind
//   (0 load x[i] and clear r[i], 1 lower-triangle matrix entry, 2 read r[i]),
//   tdata holds row index, column index and Q16.16 value.
//   m_* channel returns exactly one result per request: tuser is the status
//   (0 ok, 1 rejected and ignored: index out of range, upper-triangle entry or unknown kind,
//   2 accumulator saturated), tdata is r[i] in Q32.32 for a good read and zero otherwise.
//   cfg_* writes matrix_size (index 0) and index_base (index 1); the user is bound
//   to write them only while idle, since the block itself does not enforce it.
// Sequence: an off-diagonal entry updates r[row] then r[col], a diagonal entry
//   r[row] only, and each result waits in the done state for a free output.
//   Entries are bounded by the single multiplier and saturating adder, used
//   once per accumulator update, and the single write port of each store.
// Reset clears the sequencer and output valid and sets matrix_size 1024,
// index_base 0; the x and r stores are not cleared and must be loaded first.
// A stalled receiver holds the result; one more request may be taken and
// worked while it waits, then the sequencer holds until the output frees.
module symmetric_sparse_matvec_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ssm_pkg::IN_DATA_W-1:0]  s_tdata,  // row_index, col_index, value, zero pad
	input  logic [1:0]                     s_tuser,  // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ssm_pkg::ACC_W-1:0]      m_tdata,  // result_value
	output logic [1:0]                     m_tuser,  // status
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [ssm_pkg::SIZE_W-1:0]     cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LOAD = 9'b000000010,
		ST_RD1  = 9'b000000100,
		ST_MUL1 = 9'b000001000,
		ST_ADD1 = 9'b000010000,
		ST_MUL2 = 9'b000100000,
		ST_ADD2 = 9'b001000000,
		ST_RDR  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [ssm_pkg::SIZE_W-1:0]          size_q;
	logic                                base_q;
	logic [ssm_pkg::POS_W-1:0]           pos_r_q;
	logic [ssm_pkg::POS_W-1:0]           pos_c_q;
	logic signed [ssm_pkg::VALUE_W-1:0]  value_q;
	logic                                diag_q;
	logic                                bad_q;
	logic                                rd_q;
	logic                                sat_q;

	logic                                m_tvalid_q;
	logic [ssm_pkg::ACC_W-1:0]           m_tdata_q;
	logic [1:0]                          m_tuser_q;

	logic [ssm_pkg::VALUE_W-1:0]         vec_mem [ssm_pkg::MAX_SIZE];
	logic [ssm_pkg::ACC_W-1:0]           acc_mem [ssm_pkg::MAX_SIZE];
	logic signed [ssm_pkg::VALUE_W-1:0]  vec_rd_q;
	logic signed [ssm_pkg::ACC_W-1:0]    acc_rd_q;

	logic [ssm_pkg::POS_W-1:0]           vec_raddr;
	logic [ssm_pkg::POS_W-1:0]           acc_raddr;
	logic [ssm_pkg::POS_W-1:0]           acc_waddr;
	logic                                acc_we;
	logic [ssm_pkg::ACC_W-1:0]           acc_wdata;

	logic [ssm_pkg::INDEX_W-1:0]         in_row;
	logic [ssm_pkg::INDEX_W-1:0]         in_col;
	logic [ssm_pkg::INDEX_W-1:0]         lim;
	logic [ssm_pkg::INDEX_W-1:0]         off_r;
	logic [ssm_pkg::INDEX_W-1:0]         off_c;
	logic                                ok_r;
	logic                                ok_c;
	logic                                accept;
	logic                                out_free;

	logic                                mul_en;
	logic signed [ssm_pkg::ACC_W-1:0]    mac_sum;
	logic                                mac_sat;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// index base subtraction and range check
	always_comb begin
		in_row = s_tdata[ssm_pkg::INDEX_W-1:0];
		in_col = s_tdata[2*ssm_pkg::INDEX_W-1:ssm_pkg::INDEX_W];
		lim    = (size_q > ssm_pkg::INDEX_W'(ssm_pkg::MAX_SIZE)) ?
		         ssm_pkg::INDEX_W'(ssm_pkg::MAX_SIZE) : size_q;
		off_r  = in_row - ssm_pkg::INDEX_W'(base_q);
		off_c  = in_col - ssm_pkg::INDEX_W'(base_q);
		ok_r   = (in_row >= ssm_pkg::INDEX_W'(base_q)) && (off_r < lim);
		ok_c   = (in_col >= ssm_pkg::INDEX_W'(base_q)) && (off_c < lim);
	end

	always_comb begin
		vec_raddr = (state_q == ST_ADD1) ? pos_r_q : pos_c_q;
		acc_raddr = (state_q == ST_ADD1 || state_q == ST_MUL2) ? pos_c_q : pos_r_q;
		acc_waddr = (state_q == ST_ADD2) ? pos_c_q : pos_r_q;
		acc_we    = (state_q == ST_LOAD) || (state_q == ST_ADD1) || (state_q == ST_ADD2);
		acc_wdata = (state_q == ST_LOAD) ? '0 : mac_sum;
		mul_en    = (state_q == ST_MUL1) || (state_q == ST_MUL2);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			vec_mem[pos_r_q] <= value_q;
		end
		vec_rd_q <= vec_mem[vec_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	ssm_mac u_mac (
		.clk    (clk),
		.mul_en (mul_en),
		.mul_a  (value_q),
		.mul_b  (vec_rd_q),
		.acc_in (acc_rd_q),
		.sum    (mac_sum),
		.sat    (mac_sat)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_r_q <= off_r[ssm_pkg::POS_W-1:0];
			pos_c_q <= off_c[ssm_pkg::POS_W-1:0];
			value_q <= s_tdata[ssm_pkg::VAL_LSB+ssm_pkg::VALUE_W-1:ssm_pkg::VAL_LSB];
			diag_q  <= (off_r == off_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= ssm_pkg::SIZE_W'(ssm_pkg::MAX_SIZE);
			base_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssm_pkg::REG_MATRIX_SIZE: size_q <= cfg_data;
				ssm_pkg::REG_INDEX_BASE:  base_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bad_q      <= 1'b0;
			rd_q       <= 1'b0;
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ssm_pkg::STAT_OK;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sat_q <= 1'b0;
						rd_q  <= 1'b0;
						bad_q <= 1'b0;
						case (s_tuser)
							ssm_pkg::REQ_LOAD: begin
								if (ok_r) begin
									state_q <= ST_LOAD;
								end else begin
									bad_q   <= 1'b1;
									state_q <= ST_DONE;
								end
							end
							ssm_pkg::REQ_ENTRY: begin
								if (ok_r && ok_c && (off_r >= off_c)) begin
									state_q <= ST_RD1;
								end else begin
									bad_q   <= 1'b1;
									state_q <= ST_DONE;
								end
							end
							ssm_pkg::REQ_READ: begin
								if (ok_r) begin
									rd_q    <= 1'b1;
									state_q <= ST_RDR;
								end else begin
									bad_q   <= 1'b1;
									state_q <= ST_DONE;
								end
							end
							default: begin
								bad_q   <= 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_LOAD: state_q <= ST_DONE;
				ST_RD1:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_ADD1;
				ST_ADD1: begin
					if (mac_sat) begin
						sat_q <= 1'b1;
					end
					state_q <= diag_q ? ST_DONE : ST_MUL2;
				end
				ST_MUL2: state_q <= ST_ADD2;
				ST_ADD2: begin
					if (mac_sat) begin
						sat_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_RDR:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rd_q ? acc_rd_q : '0;
						m_tuser_q  <= bad_q ? ssm_pkg::STAT_BAD :
						              sat_q ? ssm_pkg::STAT_SAT : ssm_pkg::STAT_OK;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* bench/tb_symmetric_sparse_matvec_top.sv */
// Self-checking bench for the symmetric sparse matrix-vector multiplier: stream stimulus, scoreboard.
`timescale 1ns / 1ps
module tb_symmetric_sparse_matvec_top;
	import ssm_pkg::*;

	typedef struct packed {
		req_t        kind;
		logic [10:0] row;
		logic [10:0] col;
		logic [31:0] val;
	} mv_req_t;

	typedef struct packed {
		status_t     st;
		logic [63:0] res;
	} mv_resp_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata   = '0;
	logic [1:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [ACC_W-1:0]     m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = 1'b0;
	logic [SIZE_W-1:0]    cfg_data  = '0;

	symmetric_sparse_matvec_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// golden copy of the block state
	logic [SIZE_W-1:0] mat_size = 11'd1024;
	logic              idx_base = 1'b0;
	logic [31:0]       x_mem [MAX_SIZE];
	logic [63:0]       r_mem [MAX_SIZE];

	mv_req_t  todo_requests [$];
	mv_resp_t due_results [$];
	mv_req_t  cur_req;
	mv_resp_t new_due, oldest_due;

	int items_taken = 0;
	int n_results = 0, n_errors = 0, n_ok = 0, n_bad = 0, n_sat = 0, n_settings = 0;
	int send_gap = 0, recv_wait = 0;
	bit send_calm = 1'b0, recv_calm = 1'b0;
	logic hold_off = 1'b0;
	int hold_cnt = 0, last_hold = -1;
	int ws [$];

	function automatic bit map_pos(input logic [10:0] raw, output logic [POS_W-1:0] pos);
		int unsigned lim, r;
		lim = (mat_size > MAX_SIZE) ? MAX_SIZE : mat_size;
		pos = '0;
		if (raw < idx_base)
			return 1'b0;
		r = raw - idx_base;
		if (r >= lim)
			return 1'b0;
		pos = r[POS_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic signed [63:0] widen(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b, output bit sat);
		logic signed [64:0] s;
		s = a + b;
		sat = (s[64] != s[63]);
		if (!sat)
			return s[63:0];
		return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
	endfunction

	task automatic compute_matvec_result(input mv_req_t q, output mv_resp_t e);
		logic [POS_W-1:0] pr, pc;
		bit okr, okc, sat1, sat2;
		logic signed [63:0] vv;
		e.st  = STAT_OK;
		e.res = '0;
		vv = widen(q.val);
		sat1 = 1'b0;
		sat2 = 1'b0;
		case (q.kind)
			REQ_LOAD: begin
				if (map_pos(q.row, pr)) begin
					x_mem[pr] = q.val;
					r_mem[pr] = '0;
				end else
					e.st = STAT_BAD;
			end
			REQ_ENTRY: begin
				okr = map_pos(q.row, pr);
				okc = map_pos(q.col, pc);
				if (!okr || !okc || pr < pc)
					e.st = STAT_BAD;
				else begin
					r_mem[pr] = sat_add(r_mem[pr], vv * widen(x_mem[pc]), sat1);
					if (pr != pc)
						r_mem[pc] = sat_add(r_mem[pc], vv * widen(x_mem[pr]), sat2);
					if (sat1 || sat2)
						e.st = STAT_SAT;
				end
			end
			REQ_READ: begin
				if (map_pos(q.row, pr))
					e.res = r_mem[pr];
				else
					e.st = STAT_BAD;
			end
			default: e.st = STAT_BAD;
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin : drive
			logic valid_n;
			valid_n = s_tvalid;
			if (s_tvalid && s_tready) begin
				compute_matvec_result(cur_req, new_due);
				due_results.push_back(new_due);
				items_taken <= items_taken + 1;
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 15);
				valid_n = 1'b0;
			end
			if (!valid_n) begin
				if (send_gap > 0)
					send_gap = send_gap - 1;
				else if (todo_requests.size() > 0) begin
					cur_req = todo_requests.pop_front();
					s_tdata <= {2'b00, cur_req.val, cur_req.col, cur_req.row};
					s_tuser <= cur_req.kind;
					valid_n = 1'b1;
				end
			end
			s_tvalid <= valid_n;
		end
	end

	// result monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results = n_results + 1;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d data %h", $time, m_tuser, m_tdata);
					n_errors = n_errors + 1;
				end else begin
					oldest_due = due_results.pop_front();
					case (oldest_due.st)
						STAT_OK:  n_ok  = n_ok + 1;
						STAT_BAD: n_bad = n_bad + 1;
						default:  n_sat = n_sat + 1;
					endcase
					if (m_tuser !== oldest_due.st) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, oldest_due.st, m_tuser);
						n_errors = n_errors + 1;
					end
					if (m_tdata !== oldest_due.res) begin
						$display("%0t: result mismatch, expected %h, actual %h",
							$time, oldest_due.res, m_tdata);
						n_errors = n_errors + 1;
					end
				end
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_wait = recv_calm ? 0 : $urandom_range(0, 15);
			end
			if (hold_off)
				m_tready <= 1'b0;
			else if (recv_wait > 0) begin
				recv_wait = recv_wait - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// long receiver stall to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			if (hold_cnt == 1)
				hold_off <= 1'b0;
		end else if ((items_taken == 400 || items_taken == 1000) && last_hold != items_taken) begin
			hold_off  <= 1'b1;
			hold_cnt  <= 300;
			last_hold <= items_taken;
		end
	end

	task automatic push_req(input req_t k, input int row, input int col, input logic [31:0] v);
		mv_req_t q;
		q.kind = k;
		q.row  = row[10:0];
		q.col  = col[10:0];
		q.val  = v;
		todo_requests.push_back(q);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [10:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MATRIX_SIZE)
			mat_size = v;
		else
			idx_base = v[0];
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (todo_requests.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom();
			2: begin
				case ($urandom_range(0, 4))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					3: v = 32'h0001_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				v = $urandom_range(0, 32'h3FFFF);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic int lim_now();
		return (mat_size > MAX_SIZE) ? MAX_SIZE : int'(mat_size);
	endfunction

	function automatic int bad_raw();
		int lim;
		lim = lim_now();
		if (idx_base && (lim + 1 > 1024 || $urandom_range(0, 1)))
			return 0;
		return $urandom_range(lim + idx_base, 1024);
	endfunction

	function automatic int ws_raw();
		return ws[$urandom_range(0, ws.size() - 1)] + idx_base;
	endfunction

	task automatic run_phase(input logic [10:0] size, input logic base, input int count);
		int lim, n, p, a, b, sel, i, j;
		bit dup;
		write_reg(REG_MATRIX_SIZE, size);
		write_reg(REG_INDEX_BASE, {10'd0, base});
		n_settings = n_settings + 1;
		lim = lim_now();
		ws.delete();
		if (lim <= 20) begin
			for (p = 0; p < lim; p++)
				ws.push_back(p);
		end else begin
			ws.push_back(0);
			ws.push_back(lim - 1);
			while (ws.size() < 20) begin
				p = $urandom_range(0, lim - 1);
				dup = 1'b0;
				foreach (ws[k])
					if (ws[k] == p)
						dup = 1'b1;
				if (!dup)
					ws.push_back(p);
			end
		end
		n = ws.size();
		@(negedge clk);
		foreach (ws[k])
			push_req(REQ_LOAD, ws[k] + idx_base, $urandom_range(0, 1024), rand_val());
		repeat (count - 2 * n) begin
			sel = $urandom_range(0, 99);
			if (n == 0)
				sel = 80 + sel % 20;
			if (sel < 50) begin
				a = ws_raw();
				b = ws_raw();
				push_req(REQ_ENTRY, (a > b) ? a : b, (a > b) ? b : a, rand_val());
			end else if (sel < 65)
				push_req(REQ_READ, ws_raw(), $urandom_range(0, 1024), $urandom());
			else if (sel < 75)
				push_req(REQ_LOAD, ws_raw(), $urandom_range(0, 1024), rand_val());
			else if (sel < 80) begin
				if (n >= 2) begin
					i = $urandom_range(0, n - 1);
					j = (i + $urandom_range(1, n - 1)) % n;
					a = (ws[i] < ws[j]) ? ws[i] : ws[j];
					b = (ws[i] < ws[j]) ? ws[j] : ws[i];
					push_req(REQ_ENTRY, a + idx_base, b + idx_base, rand_val());
				end else
					push_req(REQ_NONE, $urandom_range(0, 1024), $urandom_range(0, 1024), $urandom());
			end else if (sel < 85)
				push_req(REQ_NONE, $urandom_range(0, 1024), $urandom_range(0, 1024), $urandom());
			else begin
				case ($urandom_range(0, 2))
					0: push_req(REQ_LOAD, bad_raw(), $urandom_range(0, 1024), $urandom());
					1: push_req(REQ_READ, bad_raw(), $urandom_range(0, 1024), $urandom());
					default: begin
						a = (n > 0) ? ws_raw() : bad_raw();
						if ($urandom_range(0, 1))
							push_req(REQ_ENTRY, bad_raw(), a, $urandom());
						else
							push_req(REQ_ENTRY, a, bad_raw(), $urandom());
					end
				endcase
			end
		end
		foreach (ws[k])
			push_req(REQ_READ, ws[k] + idx_base, $urandom_range(0, 1024), $urandom());
		wait_idle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: extremes, saturation on one and both halves, rejects
		push_req(REQ_LOAD, 0, 0, 32'h7FFF_FFFF);
		push_req(REQ_LOAD, 1023, 0, 32'h8000_0000);
		push_req(REQ_LOAD, 1, 0, 32'h0001_0000);
		push_req(REQ_LOAD, 2, 0, 32'h7FFF_FFFF);
		push_req(REQ_LOAD, 3, 0, 32'h7FFF_FFFF);
		push_req(REQ_LOAD, 1024, 1024, 32'hFFFF_FFFF);
		repeat (3) push_req(REQ_ENTRY, 0, 0, 32'h7FFF_FFFF);
		push_req(REQ_READ, 0, 0, 32'h0);
		push_req(REQ_ENTRY, 1023, 0, 32'h8000_0000);
		repeat (2) push_req(REQ_ENTRY, 1023, 1023, 32'h7FFF_FFFF);
		push_req(REQ_READ, 1023, 0, 32'h0);
		repeat (3) push_req(REQ_ENTRY, 3, 2, 32'h7FFF_FFFF);
		push_req(REQ_ENTRY, 1, 0, 32'h0001_0000);
		push_req(REQ_ENTRY, 0, 1, 32'h0001_0000);
		push_req(REQ_ENTRY, 1024, 0, 32'h0001_0000);
		push_req(REQ_ENTRY, 1, 1024, 32'h0001_0000);
		push_req(REQ_READ, 1024, 1024, 32'hFFFF_FFFF);
		push_req(REQ_NONE, 1024, 1024, 32'hFFFF_FFFF);
		push_req(REQ_READ, 1, 0, 32'h0);
		push_req(REQ_READ, 2, 0, 32'h0);
		push_req(REQ_READ, 3, 0, 32'h0);
		wait_idle();

		run_phase(11'd1, 1'b0, 60);
		run_phase(11'd1024, 1'b1, 220);
		run_phase(11'd16, 1'b1, 160);
		run_phase(11'd0, 1'b0, 12);
		run_phase(11'd2047, 1'b0, 180);
		run_phase(11'd8, 1'b1, 140);
		run_phase(11'd300, 1'b0, 180);
		run_phase(11'd1024, 1'b0, 200);
		run_phase(11'd2, 1'b1, 80);
		run_phase(11'd64, 1'b1, 120);

		$display("Ran %0d requests over %0d size/base settings, %0d results checked.",
			items_taken, n_settings, n_results);
		$display("Results: %0d ok, %0d rejected, %0d saturated; %0d mismatches.",
			n_ok, n_bad, n_sat, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout at %0t with %0d results outstanding", $time, due_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
